// ----- rtl/core/dpst_pkg.sv -----
// Shared constants for the dense Prim spanning tree block.
// Holds default sizes, reset values and operation codes; no dependencies.
`default_nettype none

package dpst_pkg;

   localparam int DPST_MAX_NODES        = 32;
   localparam int DPST_WEIGHT_BITS      = 16;
   localparam int DPST_RESET_NODE_COUNT = 32;

   localparam logic OP_ADD_EDGE = 1'b0;
   localparam logic OP_SOLVE    = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/dense_prim_spanning_tree.sv -----
// Top level of the dense Prim spanning tree block.
// Depends on dpst_pkg for default sizes and operation codes.
`default_nettype none

// Add-edge words load a MAX_NODES x MAX_NODES weight matrix held in one
// single-port-read memory; a parallel edge keeps the lighter weight, and
// self-loops or endpoints at or above the node count are dropped. After an
// accepted edge word req_ready stays low through the read, the compare and
// first write, and the mirrored write when the new weight is lighter,
// through the read and compare alone when the stored weight stays, and not
// at all for a dropped edge. A solve word runs Prim from node 0 on one
// shared compare unit that walks one matrix entry per cycle: it sets up the
// keys of all n nodes, then for each attached node does one select, n row
// reads and a drain (at most n rounds), plus one closing select; each result
// word is then read, loaded and held until rsp_ready is high. The results
// come out one per node in ascending order, the last one carrying the tree
// cost and the spanning flag. After the last result, and after reset, the
// matrix is cleared by a sweep over all 4^clog2(MAX_NODES) words (1024 at
// the default size), one word per cycle; req_ready stays low during every
// phase except idle. csr writes are taken at any time but must only be
// issued while the block is idle.
module dense_prim_spanning_tree
   import dpst_pkg::*;
#(
   parameter int MAX_NODES   = DPST_MAX_NODES,
   parameter int WEIGHT_BITS = DPST_WEIGHT_BITS
) (
   input  wire                                            clock,
   input  wire                                            reset,
   input  wire                                            csr_write_enable,
   input  wire  [$clog2(MAX_NODES+1)-1:0]                 csr_write_data,
   input  wire                                            req_valid,
   output logic                                           req_ready,
   input  wire                                            req_operation,
   input  wire  [$clog2(MAX_NODES)-1:0]                   req_vertex_a,
   input  wire  [$clog2(MAX_NODES)-1:0]                   req_vertex_b,
   input  wire  [WEIGHT_BITS-1:0]                         req_edge_weight,
   output logic                                           rsp_valid,
   input  wire                                            rsp_ready,
   output logic [$clog2(MAX_NODES)-1:0]                   rsp_node_index,
   output logic signed [$clog2(MAX_NODES):0]              rsp_parent_node,
   output logic [WEIGHT_BITS-1:0]                         rsp_link_cost,
   output logic [WEIGHT_BITS+$clog2(MAX_NODES)-1:0]       rsp_total_cost,
   output logic                                           rsp_spanning,
   output logic                                           rsp_last
);

   localparam int VW  = $clog2(MAX_NODES);
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int KW  = WEIGHT_BITS + 1;
   localparam int TW  = WEIGHT_BITS + VW;
   localparam int AW  = 2 * VW;
   localparam int MD  = 1 << AW;
   localparam int RESET_COUNT =
      (MAX_NODES < DPST_RESET_NODE_COUNT) ? MAX_NODES : DPST_RESET_NODE_COUNT;

   localparam logic [KW-1:0]  INF_KEY   = {1'b1, {WEIGHT_BITS{1'b0}}};
   localparam logic [NCW-1:0] NODES_MAX = NCW'(MAX_NODES);
   localparam logic [NCW-1:0] ONE_N     = NCW'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE_RD,
      S_EDGE_CMP,
      S_EDGE_WR2,
      S_INIT,
      S_RELAX,
      S_SELECT,
      S_OUT_RD,
      S_OUT_LOAD,
      S_OUT_WAIT,
      S_CLEAR
   } state_type;

   state_type state_ff, state_in;

   logic [NCW-1:0]   count_ff, count_in;
   logic [VW-1:0]    a_ff, a_in;
   logic [VW-1:0]    b_ff, b_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [NCW-1:0]   idx_ff, idx_in;
   logic             proc_vld_ff, proc_vld_in;
   logic [VW-1:0]    idx_d_ff, idx_d_in;
   logic [VW-1:0]    pick_ff, pick_in;
   logic [VW-1:0]    cand_ff, cand_in;
   logic [KW-1:0]    low_ff, low_in;
   logic             found_ff, found_in;
   logic [TW-1:0]    cost_ff, cost_in;
   logic [NCW-1:0]   attached_ff, attached_in;
   logic [AW-1:0]    clr_ff, clr_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]    rsp_index_ff, rsp_index_in;
   logic [VW:0]      rsp_parent_ff, rsp_parent_in;
   logic [WEIGHT_BITS-1:0] rsp_link_ff, rsp_link_in;
   logic [TW-1:0]    rsp_total_ff, rsp_total_in;
   logic             rsp_span_ff, rsp_span_in;
   logic             rsp_last_ff, rsp_last_in;

   // weight matrix and per-node Prim state
   logic [KW-1:0]    mat_mem [MD];
   logic [KW-1:0]    mat_q_ff;
   logic [KW-1:0]    key_mem [MAX_NODES];
   logic [VW:0]      par_mem [MAX_NODES];
   logic             tree_mem [MAX_NODES];
   logic [KW-1:0]    key_q_ff;
   logic [VW:0]      par_q_ff;
   logic             tree_q_ff;

   logic             mat_we;
   logic [AW-1:0]    mat_waddr;
   logic [KW-1:0]    mat_wdata;
   logic [AW-1:0]    mat_raddr;
   logic             node_we;
   logic [VW-1:0]    node_waddr;
   logic [KW-1:0]    node_wkey;
   logic [VW:0]      node_wpar;
   logic             node_wtree;

   logic [NCW-1:0]   active_n;
   logic             edge_ok;
   logic             idx_is_last;
   logic             p_tree;
   logic             p_relax;
   logic [KW-1:0]    p_key;
   logic [VW:0]      p_par;
   logic             p_cand;

   always_comb begin
      if (count_ff == '0) begin
         active_n = ONE_N;
      end else if (count_ff > NODES_MAX) begin
         active_n = NODES_MAX;
      end else begin
         active_n = count_ff;
      end
   end

   assign edge_ok = (NCW'(req_vertex_a) < active_n) && (NCW'(req_vertex_b) < active_n) &&
                    (req_vertex_a != req_vertex_b);
   assign idx_is_last = (NCW'(idx_ff + ONE_N) == active_n);

   // relax one node against the row of the newest tree node, track the minimum
   assign p_tree  = tree_q_ff | (idx_d_ff == pick_ff);
   assign p_relax = !p_tree && (mat_q_ff < key_q_ff);
   assign p_key   = p_relax ? mat_q_ff : key_q_ff;
   assign p_par   = p_relax ? {1'b1, pick_ff} : par_q_ff;
   assign p_cand  = !p_tree && (p_key < low_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = csr_write_enable ? csr_write_data : count_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      w_in          = w_ff;
      idx_in        = idx_ff;
      proc_vld_in   = 1'b0;
      idx_d_in      = idx_d_ff;
      pick_in       = pick_ff;
      cand_in       = cand_ff;
      low_in        = low_ff;
      found_in      = found_ff;
      cost_in       = cost_ff;
      attached_in   = attached_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_parent_in = rsp_parent_ff;
      rsp_link_in   = rsp_link_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_span_in   = rsp_span_ff;
      rsp_last_in   = rsp_last_ff;
      req_ready     = 1'b0;
      mat_we        = 1'b0;
      mat_waddr     = {a_ff, b_ff};
      mat_wdata     = {1'b0, w_ff};
      mat_raddr     = {pick_ff, idx_ff[VW-1:0]};
      node_we       = 1'b0;
      node_waddr    = idx_d_ff;
      node_wkey     = p_key;
      node_wpar     = p_par;
      node_wtree    = p_tree;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_SOLVE) begin
                  idx_in      = '0;
                  low_in      = '0;
                  cand_in     = '0;
                  found_in    = 1'b1;
                  cost_in     = '0;
                  attached_in = '0;
                  state_in    = S_INIT;
               end else begin
                  a_in = req_vertex_a;
                  b_in = req_vertex_b;
                  w_in = req_edge_weight;
                  if (edge_ok) begin
                     state_in = S_EDGE_RD;
                  end
               end
            end
         end
         S_EDGE_RD: begin
            mat_raddr = {a_ff, b_ff};
            state_in  = S_EDGE_CMP;
         end
         S_EDGE_CMP: begin
            if ({1'b0, w_ff} < mat_q_ff) begin
               mat_we   = 1'b1;
               state_in = S_EDGE_WR2;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EDGE_WR2: begin
            mat_we    = 1'b1;
            mat_waddr = {b_ff, a_ff};
            state_in  = S_IDLE;
         end
         S_INIT: begin
            // node 0 starts at key zero, so it is the first pick
            node_we    = 1'b1;
            node_waddr = idx_ff[VW-1:0];
            node_wkey  = (idx_ff == '0) ? '0 : INF_KEY;
            node_wpar  = '0;
            node_wtree = 1'b0;
            if (idx_is_last) begin
               state_in = S_SELECT;
            end else begin
               idx_in = NCW'(idx_ff + ONE_N);
            end
         end
         S_SELECT: begin
            idx_in = '0;
            if (found_ff) begin
               pick_in     = cand_ff;
               cost_in     = TW'(cost_ff + TW'(low_ff[WEIGHT_BITS-1:0]));
               attached_in = NCW'(attached_ff + ONE_N);
               low_in      = INF_KEY;
               found_in    = 1'b0;
               state_in    = S_RELAX;
            end else begin
               state_in = S_OUT_RD;
            end
         end
         S_RELAX: begin
            if (idx_ff < active_n) begin
               proc_vld_in = 1'b1;
               idx_d_in    = idx_ff[VW-1:0];
               idx_in      = NCW'(idx_ff + ONE_N);
            end
            if (proc_vld_ff) begin
               node_we = 1'b1;
               if (p_cand) begin
                  low_in   = p_key;
                  cand_in  = idx_d_ff;
                  found_in = 1'b1;
               end
            end
            if (idx_ff == active_n && !proc_vld_ff) begin
               state_in = S_SELECT;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_LOAD;
         end
         S_OUT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = idx_ff[VW-1:0];
            if (tree_q_ff && par_q_ff[VW]) begin
               rsp_parent_in = {1'b0, par_q_ff[VW-1:0]};
               rsp_link_in   = key_q_ff[WEIGHT_BITS-1:0];
            end else begin
               rsp_parent_in = '1;
               rsp_link_in   = '0;
            end
            rsp_total_in = idx_is_last ? cost_ff : '0;
            rsp_span_in  = idx_is_last && (attached_ff == active_n);
            rsp_last_in  = idx_is_last;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end else begin
                  idx_in   = NCW'(idx_ff + ONE_N);
                  state_in = S_OUT_RD;
               end
            end
         end
         S_CLEAR: begin
            mat_we    = 1'b1;
            mat_waddr = clr_ff;
            mat_wdata = INF_KEY;
            clr_in    = AW'(clr_ff + AW'(1));
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= NCW'(RESET_COUNT);
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         proc_vld_ff  <= proc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      w_ff          <= w_in;
      idx_ff        <= idx_in;
      idx_d_ff      <= idx_d_in;
      pick_ff       <= pick_in;
      cand_ff       <= cand_in;
      low_ff        <= low_in;
      found_ff      <= found_in;
      cost_ff       <= cost_in;
      attached_ff   <= attached_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_parent_ff <= rsp_parent_in;
      rsp_link_ff   <= rsp_link_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_span_ff   <= rsp_span_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_waddr] <= mat_wdata;
      end
      mat_q_ff <= mat_mem[mat_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         key_mem[node_waddr]  <= node_wkey;
         par_mem[node_waddr]  <= node_wpar;
         tree_mem[node_waddr] <= node_wtree;
      end
      key_q_ff  <= key_mem[idx_ff[VW-1:0]];
      par_q_ff  <= par_mem[idx_ff[VW-1:0]];
      tree_q_ff <= tree_mem[idx_ff[VW-1:0]];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_index  = rsp_index_ff;
   assign rsp_parent_node = rsp_parent_ff;
   assign rsp_link_cost   = rsp_link_ff;
   assign rsp_total_cost  = rsp_total_ff;
   assign rsp_spanning    = rsp_span_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

// ----- tb/sv/dense_prim_spanning_tree_test.sv -----
// Self-checking testbench for dense_prim_spanning_tree: directed table, then random graphs.
// Each result word is checked against a local Prim predictor.
// Depends on dpst_pkg and the dense_prim_spanning_tree RTL only.
`timescale 1ns / 100ps

module dense_prim_spanning_tree_test;
   import dpst_pkg::*;

   localparam int NODES          = DPST_MAX_NODES;
   localparam int WBITS          = DPST_WEIGHT_BITS;
   localparam logic [WBITS:0] NO_EDGE = {1'b1, {WBITS{1'b0}}};
   localparam int SETTLE_CYCLES  = 1100;   // covers the clear sweep plus a pending edge update
   localparam int WATCHDOG_LIMIT = 20000;

   typedef enum {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic              op;
      logic [4:0]        va;
      logic [4:0]        vb;
      logic [WBITS-1:0]  wt;
      bit                typed;
      logic [20:0]       total;
      logic              spanning;
      logic [5:0]        count;
   } plan_row_type;

   typedef struct {
      logic [4:0]        node;
      logic signed [5:0] parent;
      logic [WBITS-1:0]  link;
      logic [20:0]       total;
      logic              spanning;
      logic              last;
   } tree_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [5:0]        csr_write_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_operation = OP_ADD_EDGE;
   logic [4:0]        req_vertex_a = '0;
   logic [4:0]        req_vertex_b = '0;
   logic [WBITS-1:0]  req_edge_weight = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [4:0]        rsp_node_index;
   logic signed [5:0] rsp_parent_node;
   logic [WBITS-1:0]  rsp_link_cost;
   logic [20:0]       rsp_total_cost;
   logic              rsp_spanning;
   logic              rsp_last;

   // predictor state
   logic [WBITS:0]    adj [NODES][NODES];
   logic [5:0]        csr_nodes;
   tree_row_type      tree_rows_due [$];

   int                mismatches = 0;
   int                quiet_cycles = 0;
   int                rand_items = 0;
   bit                steady = 1'b0;

   dense_prim_spanning_tree u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .req_edge_weight  (req_edge_weight),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_node_index   (rsp_node_index),
      .rsp_parent_node  (rsp_parent_node),
      .rsp_link_cost    (rsp_link_cost),
      .rsp_total_cost   (rsp_total_cost),
      .rsp_spanning     (rsp_spanning),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int active_nodes();
      int n;
      n = csr_nodes;
      if (n < 1) n = 1;
      if (n > NODES) n = NODES;
      return n;
   endfunction

   task automatic clear_adjacency();
      for (int i = 0; i < NODES; i++)
         for (int j = 0; j < NODES; j++)
            adj[i][j] = NO_EDGE;
   endtask

   task automatic store_edge(input logic [4:0] a, input logic [4:0] b,
                             input logic [WBITS-1:0] w);
      int n;
      n = active_nodes();
      if (a < n && b < n && a != b && {1'b0, w} < adj[a][b]) begin
         adj[a][b] = {1'b0, w};
         adj[b][a] = {1'b0, w};
      end
   endtask

   // Grow the tree from node 0 and queue one word per node.
   task automatic prim_tree(input bit typed, input logic [20:0] typed_total,
                            input logic typed_span);
      logic [WBITS:0] key [NODES];
      int             par [NODES];
      bit             attached [NODES];
      logic [WBITS:0] low;
      logic [20:0]    cost;
      int             n;
      int             pick;
      bit             all;
      tree_row_type   row;
      n = active_nodes();
      for (int i = 0; i < NODES; i++) begin
         key[i] = NO_EDGE;
         par[i] = -1;
         attached[i] = 1'b0;
      end
      key[0] = '0;
      cost = '0;
      for (int round = 0; round < n; round++) begin
         pick = n;
         low = NO_EDGE;
         for (int i = 0; i < n; i++) begin
            if (!attached[i] && key[i] < low) begin
               low = key[i];
               pick = i;
            end
         end
         // stop growing once nothing reachable is left
         if (pick >= n) break;
         attached[pick] = 1'b1;
         cost = cost + low;
         for (int i = 0; i < n; i++) begin
            if (!attached[i] && adj[pick][i] < key[i]) begin
               key[i] = adj[pick][i];
               par[i] = pick;
            end
         end
      end
      all = 1'b1;
      for (int i = 0; i < n; i++)
         if (!attached[i]) all = 1'b0;
      for (int i = 0; i < n; i++) begin
         row.node = 5'(i);
         if (attached[i] && par[i] >= 0) begin
            row.parent = 6'(par[i]);
            row.link = key[i][WBITS-1:0];
         end else begin
            row.parent = '1;
            row.link = '0;
         end
         row.last = (i == n - 1);
         row.total = row.last ? cost : '0;
         row.spanning = row.last && all;
         if (row.last && typed) begin
            row.total = typed_total;
            row.spanning = typed_span;
         end
         tree_rows_due.insert(tree_rows_due.size(), row);
      end
      clear_adjacency();
   endtask

   function automatic plan_row_type edge_row(input logic [4:0] a, input logic [4:0] b,
                                             input logic [WBITS-1:0] w);
      plan_row_type r;
      r.kind = ROW_WORD;
      r.op = OP_ADD_EDGE;
      r.va = a;
      r.vb = b;
      r.wt = w;
      r.typed = 1'b0;
      r.total = '0;
      r.spanning = 1'b0;
      r.count = '0;
      return r;
   endfunction

   function automatic plan_row_type solve_row(input bit typed, input logic [20:0] total,
                                              input logic spanning);
      plan_row_type r;
      r.kind = ROW_WORD;
      r.op = OP_SOLVE;
      r.va = '0;
      r.vb = '0;
      r.wt = '0;
      r.typed = typed;
      r.total = total;
      r.spanning = spanning;
      r.count = '0;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [5:0] count);
      plan_row_type r;
      r = edge_row('0, '0, '0);
      r.kind = ROW_CSR;
      r.count = count;
      return r;
   endfunction

   function automatic logic [WBITS-1:0] pick_weight();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) return WBITS'($urandom_range(0, 15));   // small range to force ties
      if (sel < 45) return '0;
      if (sel < 50) return '1;
      return WBITS'($urandom);
   endfunction

   // Ends at a rising edge; one word per call.
   task automatic send_word(input plan_row_type r);
      steady = (rand_items >= 40 && rand_items < 75);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= r.op;
      req_vertex_a    <= r.va;
      req_vertex_b    <= r.vb;
      req_edge_weight <= r.wt;
      do @(posedge clock); while (!req_ready);
      if (r.op == OP_ADD_EDGE) store_edge(r.va, r.vb, r.wt);
      else prim_tree(r.typed, r.total, r.spanning);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tree_rows_due.size() != 0) @(negedge clock);
   endtask

   // Write only once the block is idle, clear sweep included.
   task automatic program_nodes(input logic [5:0] count);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_nodes = count;
   endtask

   task automatic random_edge(input int a, input int b);
      send_word(edge_row(5'(a), 5'(b), pick_weight()));
      rand_items++;
   endtask

   task automatic check_field(input string name, input logic [20:0] want,
                              input logic [20:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= steady || ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin : check_results
      tree_row_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tree_rows_due.size() == 0) begin
            $display("%0t unexpected result word: expected none actual node %0d",
                     $time, rsp_node_index);
            mismatches++;
         end else begin
            due = tree_rows_due.pop_front();
            check_field("node_index", due.node, rsp_node_index);
            check_field("parent_node", due.parent, rsp_parent_node);
            check_field("link_cost", due.link, rsp_link_cost);
            check_field("total_cost", due.total, rsp_total_cost);
            check_field("spanning", due.spanning, rsp_spanning);
            check_field("last", due.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type dir_rows [$];
      logic [5:0] count;
      int         n;
      int         graphs;
      int         sel;
      bit         paused;
      clear_adjacency();
      csr_nodes = DPST_RESET_NODE_COUNT;
      paused = 1'b0;

      // empty graph at reset size: only the root is reached
      dir_rows.insert(dir_rows.size(), solve_row(1, 21'd0, 1'b0));
      // zero acts as a single node
      dir_rows.insert(dir_rows.size(), csr_row(6'd0));
      dir_rows.insert(dir_rows.size(), edge_row(5'd0, 5'd1, 16'd5));
      dir_rows.insert(dir_rows.size(), solve_row(1, 21'd0, 1'b1));
      // oversize count acts as full size; parallel edges, self-loop, split graph
      dir_rows.insert(dir_rows.size(), csr_row(6'd63));
      dir_rows.insert(dir_rows.size(), edge_row(5'd0, 5'd31, 16'hFFFF));
      dir_rows.insert(dir_rows.size(), edge_row(5'd31, 5'd0, 16'hFFFF));
      dir_rows.insert(dir_rows.size(), edge_row(5'd7, 5'd7, 16'd0));
      dir_rows.insert(dir_rows.size(), edge_row(5'd31, 5'd30, 16'd0));
      dir_rows.insert(dir_rows.size(), edge_row(5'd1, 5'd0, 16'd100));
      dir_rows.insert(dir_rows.size(), edge_row(5'd0, 5'd1, 16'd200));
      dir_rows.insert(dir_rows.size(), edge_row(5'd0, 5'd1, 16'd50));
      dir_rows.insert(dir_rows.size(), edge_row(5'd30, 5'd16, 16'h5555));
      dir_rows.insert(dir_rows.size(), edge_row(5'd10, 5'd21, 16'hAAAA));
      dir_rows.insert(dir_rows.size(), solve_row(0, '0, 1'b0));
      // out-of-range endpoint dropped; heaviest chain
      dir_rows.insert(dir_rows.size(), csr_row(6'd3));
      dir_rows.insert(dir_rows.size(), edge_row(5'd0, 5'd3, 16'd1));
      dir_rows.insert(dir_rows.size(), edge_row(5'd0, 5'd1, 16'hFFFF));
      dir_rows.insert(dir_rows.size(), edge_row(5'd2, 5'd1, 16'hFFFF));
      dir_rows.insert(dir_rows.size(), solve_row(1, 21'd131070, 1'b1));
      // equal keys resolve to the lowest index
      dir_rows.insert(dir_rows.size(), edge_row(5'd0, 5'd1, 16'd10));
      dir_rows.insert(dir_rows.size(), edge_row(5'd0, 5'd2, 16'd10));
      dir_rows.insert(dir_rows.size(), edge_row(5'd1, 5'd2, 16'd10));
      dir_rows.insert(dir_rows.size(), solve_row(0, '0, 1'b0));
      // shrink the count after loading: the edge 2-3 drops out
      dir_rows.insert(dir_rows.size(), csr_row(6'd4));
      dir_rows.insert(dir_rows.size(), edge_row(5'd0, 5'd1, 16'd7));
      dir_rows.insert(dir_rows.size(), edge_row(5'd2, 5'd3, 16'd9));
      dir_rows.insert(dir_rows.size(), csr_row(6'd2));
      dir_rows.insert(dir_rows.size(), solve_row(1, 21'd7, 1'b1));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) program_nodes(dir_rows[i].count);
         else send_word(dir_rows[i]);
      end

      // the directed table sends 24 words; the random part fills up to about 120
      while (rand_items < 96) begin
         sel = $urandom_range(99);
         if (sel < 55) count = 6'($urandom_range(2, 8));
         else if (sel < 72) count = 6'($urandom_range(9, 31));
         else if (sel < 80) count = 6'd32;
         else if (sel < 88) count = 6'($urandom_range(0, 1));
         else count = 6'($urandom_range(33, 63));
         program_nodes(count);
         n = active_nodes();
         graphs = (n == NODES) ? 1 : $urandom_range(1, 3);
         repeat (graphs) begin
            if ($urandom_range(99) < 70) begin
               // connected: every node hangs off an earlier one, plus extra edges
               for (int k = 1; k < n; k++) begin
                  sel = $urandom_range(0, k - 1);
                  if ($urandom_range(1)) random_edge(k, sel);
                  else random_edge(sel, k);
               end
               repeat ($urandom_range(0, n))
                  random_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
            end else begin
               repeat ($urandom_range(0, 12))
                  random_edge($urandom_range(0, 31), $urandom_range(0, 31));
            end
            send_word(solve_row(0, '0, 1'b0));
            rand_items++;
            if (!paused || $urandom_range(99) < 15) begin
               hold_until_drained();
               paused = 1'b1;
            end
         end
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
